>>> rtl/sm83_pkg.sv
// Package with shared types and constants for the SM83 instruction core.
package sm83_pkg;

  localparam logic [3:0] FLAG_Z = 4'b1000;
  localparam logic [3:0] FLAG_N = 4'b0100;
  localparam logic [3:0] FLAG_H = 4'b0010;
  localparam logic [3:0] FLAG_C = 4'b0001;

  localparam logic [7:0] OP_STOP = 8'h10;
  localparam logic [7:0] OP_HALT = 8'h76;
  localparam logic [7:0] OP_LDSP = 8'h08;
  localparam logic [7:0] OP_LDHLN = 8'h36;
  localparam logic [7:0] OP_INCM = 8'h34;
  localparam logic [7:0] OP_DECM = 8'h35;
  localparam logic [7:0] OP_JR = 8'h18;
  localparam logic [7:0] OP_JP = 8'hc3;
  localparam logic [7:0] OP_JPHL = 8'he9;

  typedef struct packed {
    logic       kind;
    logic [7:0] read_data;
  } sm83_in_t;

  typedef struct packed {
    logic [15:0] bus_address;
    logic [7:0]  bus_write_data;
    logic        bus_is_write;
    logic        instr_retired;
    logic [7:0]  retired_opcode;
    logic [4:0]  retired_cycles;
    logic        unimplemented_op;
    logic        stop_or_halt;
    logic [7:0]  accumulator;
    logic [3:0]  flags_znhc;
  } sm83_out_t;

  // Architectural state of the core.
  typedef struct packed {
    logic [7:0]  a;
    logic [7:0]  b, c, d, e, h, l;
    logic [15:0] sp;
    logic [15:0] pc;
    logic [3:0]  f;
    logic [7:0]  op;
    logic [2:0]  phase;
    logic [7:0]  t0, t1;
  } sm83_state_t;

endpackage

>>> rtl/sm83_if.sv
// Valid/ready channel interfaces for the core's input and result streams.
interface sm83_in_if import sm83_pkg::*; ();
  logic     valid;
  logic     ready;
  sm83_in_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface sm83_out_if import sm83_pkg::*; ();
  logic      valid;
  logic      ready;
  sm83_out_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

>>> rtl/sm83_exec.sv
// Combinational step of the core: next state and bus request for one transaction.
module sm83_exec import sm83_pkg::*; (
  input  sm83_state_t st,
  input  logic [15:0] start_addr,
  input  sm83_in_t    in,
  output sm83_state_t ns,
  output sm83_out_t   res
);

  function automatic logic [7:0] rget(input sm83_state_t s, input logic [2:0] sel);
    logic [7:0] v;
    case (sel)
      3'd0: v = s.b;
      3'd1: v = s.c;
      3'd2: v = s.d;
      3'd3: v = s.e;
      3'd4: v = s.h;
      3'd5: v = s.l;
      3'd6: v = 8'h00;
      default: v = s.a;
    endcase
    return v;
  endfunction

  function automatic logic [15:0] pget(input sm83_state_t s, input logic [1:0] i);
    logic [15:0] v;
    case (i)
      2'd0: v = {s.b, s.c};
      2'd1: v = {s.d, s.e};
      2'd2: v = {s.h, s.l};
      default: v = s.sp;
    endcase
    return v;
  endfunction

  function automatic logic needs_bus(input logic [7:0] c);
    logic n;
    if (c < 8'h40)
      n = (c == OP_LDSP) || (c[2:0] == 3'd6) || (c == OP_INCM) || (c == OP_DECM) ||
          (c[3:0] == 4'h1) || (c[3:0] == 4'h2) ||
          (c[3:0] == 4'ha) || (c == OP_JR) || (c == 8'h20) || (c == 8'h28) ||
          (c == 8'h30) || (c == 8'h38);
    else if (c < 8'h80)
      n = (c != OP_HALT) && ((c[2:0] == 3'd6) || (c[7:3] == 5'b01110));
    else if (c < 8'hc0)
      n = (c[2:0] == 3'd6);
    else
      n = (c == 8'hc2) || (c == OP_JP) || (c == 8'hca) || (c == 8'hd2) || (c == 8'hda);
    return n;
  endfunction

  function automatic logic cond_ok(input logic [3:0] f, input logic [7:0] c);
    logic k;
    case (c[4:3])
      2'd0: k = !f[3];
      2'd1: k = f[3];
      2'd2: k = !f[0];
      default: k = f[0];
    endcase
    return k;
  endfunction

  always_comb begin
    logic [7:0]  code, rd, v8, r8, av;
    logic [2:0]  r, p;
    logic [1:0]  i;
    logic        fin, unimpl, hlt, dn, cin;
    logic [4:0]  cyc;
    logic [15:0] pv, hl;
    logic [16:0] s17;
    logic [8:0]  s9, da;
    logic [4:0]  s5;
    logic [3:0]  fl;
    logic [15:0] base;
    logic        wsel, wen;
    logic [2:0]  wreg;
    logic [7:0]  wval;
    logic        pwen;
    logic [1:0]  pwi;
    logic [15:0] pwv;

    ns = st;
    rd = in.read_data;
    fin = 1'b0; cyc = 5'd0; unimpl = 1'b0; hlt = 1'b0;
    wen = 1'b0; wreg = 3'd0; wval = 8'h00;
    pwen = 1'b0; pwi = 2'd0; pwv = 16'h0;
    code = st.op; p = st.phase;
    r = 3'd0; i = 2'd0; v8 = 8'h00; r8 = 8'h00; dn = 1'b0; cin = 1'b0;
    pv = 16'h0; s17 = 17'h0; s9 = 9'h0; s5 = 5'h0; fl = st.f; av = st.a; da = 9'h0;
    wsel = 1'b0; base = 16'h0; hl = {st.h, st.l};

    if (!in.kind) begin
      ns.pc = start_addr;
      ns.phase = 3'd0;
    end else if (st.phase == 3'd0) begin
      code = rd;
      ns.op = rd;
      ns.pc = st.pc + 16'd1;
      r = code[5:3];
      i = code[5:4];
      if (needs_bus(rd)) begin
        ns.phase = 3'd1;
      end else if (code == OP_STOP || code == OP_HALT) begin
        hlt = 1'b1; fin = 1'b1; cyc = 5'd0;
      end else if (code[7:6] == 2'b01) begin
        wen = 1'b1; wreg = r; wval = rget(st, code[2:0]); fin = 1'b1; cyc = 5'd4;
      end else if (code[7:6] == 2'b10) begin
        wsel = 1'b1; v8 = rget(st, code[2:0]); fin = 1'b1; cyc = 5'd4;
      end else if (code == OP_JPHL) begin
        ns.pc = hl; fin = 1'b1; cyc = 5'd4;
      end else if (code[7:6] == 2'b11) begin
        unimpl = 1'b1; fin = 1'b1; cyc = 5'd4;
      end else begin
        fin = 1'b1; cyc = 5'd4;
        case (code[2:0])
          3'd3: begin
            pwen = 1'b1; pwi = i;
            pwv = pget(st, i) + (code[3] ? 16'hffff : 16'h0001);
            cyc = 5'd8;
          end
          3'd1: begin
            pv = pget(st, i);
            s17 = {1'b0, hl} + {1'b0, pv};
            fl = {st.f[3], 1'b0, ({1'b0, hl[11:0]} + {1'b0, pv[11:0]}) > 13'hfff, s17[16]};
            ns.f = fl;
            pwen = 1'b1; pwi = 2'd2; pwv = s17[15:0];
            cyc = 5'd8;
          end
          3'd4, 3'd5: begin
            dn = code[0];
            r8 = rget(st, r) + (dn ? 8'hff : 8'h01);
            ns.f = {r8 == 8'h00, dn, dn ? (r8[3:0] == 4'hf) : (r8[3:0] == 4'h0), st.f[0]};
            wen = 1'b1; wreg = r; wval = r8;
          end
          3'd7: begin
            cin = st.f[0];
            case (code)
              8'h07: begin av = {st.a[6:0], st.a[7]}; fl = {3'b000, st.a[7]}; end
              8'h17: begin av = {st.a[6:0], cin}; fl = {3'b000, st.a[7]}; end
              8'h0f: begin av = {st.a[0], st.a[7:1]}; fl = {3'b000, st.a[0]}; end
              8'h1f: begin av = {cin, st.a[7:1]}; fl = {3'b000, st.a[0]}; end
              8'h27: begin
                da = {1'b0, st.a};
                if (!st.f[2]) begin
                  if (cin || st.a > 8'h99) begin da = da + 9'h060; cin = 1'b1; end
                  if (st.f[1] || da[3:0] > 4'd9) da = da + 9'h006;
                end else begin
                  if (cin) da = da + 9'h0a0;
                  if (st.f[1]) da = da + 9'h0fa;
                end
                av = da[7:0];
                fl = {av == 8'h00, st.f[2], 1'b0, cin};
              end
              8'h2f: begin av = ~st.a; fl = st.f | FLAG_N | FLAG_H; end
              8'h37: fl = {st.f[3], 3'b001};
              default: fl = {st.f[3], 2'b00, ~cin};
            endcase
            ns.a = av; ns.f = fl;
          end
          default: ;
        endcase
      end
    end else begin
      r = code[5:3];
      if (code == OP_LDSP) begin
        if (p == 3'd1) begin ns.t0 = rd; ns.pc = st.pc + 16'd1; end
        if (p == 3'd2) begin ns.t1 = rd; ns.pc = st.pc + 16'd1; end
        if (p < 3'd4) ns.phase = p + 3'd1;
        else begin fin = 1'b1; cyc = 5'd20; end
      end else if (code < 8'h40 && code[3:0] == 4'h1) begin
        ns.pc = st.pc + 16'd1;
        if (p == 3'd1) begin ns.t0 = rd; ns.phase = 3'd2; end
        else begin
          pwen = 1'b1; pwi = code[5:4]; pwv = {rd, st.t0}; fin = 1'b1; cyc = 5'd12;
        end
      end else if (code == OP_LDHLN) begin
        if (p == 3'd1) begin ns.pc = st.pc + 16'd1; ns.t0 = rd; ns.phase = 3'd2; end
        else begin fin = 1'b1; cyc = 5'd12; end
      end else if (code == OP_INCM || code == OP_DECM) begin
        if (p == 3'd1) begin
          dn = code[0];
          r8 = rd + (dn ? 8'hff : 8'h01);
          ns.f = {r8 == 8'h00, dn, dn ? (r8[3:0] == 4'hf) : (r8[3:0] == 4'h0), st.f[0]};
          ns.t0 = r8; ns.phase = 3'd2;
        end else begin fin = 1'b1; cyc = 5'd12; end
      end else if (code < 8'h40 && code[2:0] == 3'd6) begin
        ns.pc = st.pc + 16'd1; wen = 1'b1; wreg = r; wval = rd; fin = 1'b1; cyc = 5'd8;
      end else if (code < 8'h40 && (code[3:0] == 4'h2 || code[3:0] == 4'ha)) begin
        if (code[3:0] == 4'ha) ns.a = rd;
        if (code[5:4] == 2'd2) begin pwen = 1'b1; pwi = 2'd2; pwv = hl + 16'd1; end
        if (code[5:4] == 2'd3) begin pwen = 1'b1; pwi = 2'd2; pwv = hl - 16'd1; end
        fin = 1'b1; cyc = 5'd8;
      end else if (code < 8'h40) begin
        ns.pc = st.pc + 16'd1;
        if (code == OP_JR || cond_ok(st.f, code)) begin
          ns.pc = st.pc + 16'd1 + {{8{rd[7]}}, rd}; cyc = 5'd12;
        end else cyc = 5'd8;
        fin = 1'b1;
      end else if (code < 8'h80) begin
        if (code[7:3] != 5'b01110) begin wen = 1'b1; wreg = r; wval = rd; end
        fin = 1'b1; cyc = 5'd8;
      end else if (code < 8'hc0) begin
        wsel = 1'b1; v8 = rd; fin = 1'b1; cyc = 5'd8;
      end else begin
        ns.pc = st.pc + 16'd1;
        if (p == 3'd1) begin ns.t0 = rd; ns.phase = 3'd2; end
        else begin
          fin = 1'b1;
          if (code == OP_JP || cond_ok(st.f, code)) begin
            ns.pc = {rd, st.t0}; cyc = 5'd16;
          end else cyc = 5'd12;
        end
      end
    end

    // ALU group: add, adc, sub, sbc, and, xor, or, cp.
    if (wsel) begin
      cin = 1'b0;
      case (r)
        3'd0, 3'd1: begin
          cin = (r == 3'd1) & st.f[0];
          s9 = {1'b0, st.a} + {1'b0, v8} + {8'h00, cin};
          s5 = {1'b0, st.a[3:0]} + {1'b0, v8[3:0]} + {4'h0, cin};
          r8 = s9[7:0];
          fl = {r8 == 8'h00, 1'b0, s5[4], s9[8]};
          ns.a = r8;
        end
        3'd2, 3'd3, 3'd7: begin
          cin = (r == 3'd3) & st.f[0];
          s9 = {1'b0, st.a} - {1'b0, v8} - {8'h00, cin};
          s5 = {1'b0, st.a[3:0]} - {1'b0, v8[3:0]} - {4'h0, cin};
          r8 = s9[7:0];
          fl = {r8 == 8'h00, 1'b1, s5[4], s9[8]};
          if (r != 3'd7) ns.a = r8;
        end
        3'd4: begin r8 = st.a & v8; fl = {r8 == 8'h00, 3'b010}; ns.a = r8; end
        3'd5: begin r8 = st.a ^ v8; fl = {r8 == 8'h00, 3'b000}; ns.a = r8; end
        default: begin r8 = st.a | v8; fl = {r8 == 8'h00, 3'b000}; ns.a = r8; end
      endcase
      ns.f = fl;
    end

    if (wen) begin
      case (wreg)
        3'd0: ns.b = wval;
        3'd1: ns.c = wval;
        3'd2: ns.d = wval;
        3'd3: ns.e = wval;
        3'd4: ns.h = wval;
        3'd5: ns.l = wval;
        3'd6: ;
        default: ns.a = wval;
      endcase
    end
    if (pwen) begin
      case (pwi)
        2'd0: {ns.b, ns.c} = pwv;
        2'd1: {ns.d, ns.e} = pwv;
        2'd2: {ns.h, ns.l} = pwv;
        default: ns.sp = pwv;
      endcase
    end
    if (fin) ns.phase = 3'd0;

    // Bus request from the updated state.
    res = '0;
    res.bus_address = ns.pc;
    hl = {ns.h, ns.l};
    i = (ns.op[5:4] == 2'd3) ? 2'd2 : ns.op[5:4];
    if (ns.phase != 3'd0) begin
      base = {ns.t1, ns.t0};
      if (ns.op == OP_LDSP && ns.phase >= 3'd3) begin
        res.bus_is_write = 1'b1;
        if (ns.phase == 3'd3) begin
          res.bus_address = base; res.bus_write_data = ns.sp[7:0];
        end else begin
          res.bus_address = base + 16'd1; res.bus_write_data = ns.sp[15:8];
        end
      end else if (ns.op == OP_LDHLN && ns.phase == 3'd2) begin
        res.bus_address = hl; res.bus_is_write = 1'b1; res.bus_write_data = ns.t0;
      end else if (ns.op == OP_INCM || ns.op == OP_DECM) begin
        res.bus_address = hl;
        if (ns.phase == 3'd2) begin res.bus_is_write = 1'b1; res.bus_write_data = ns.t0; end
      end else if (ns.op < 8'h40 && ns.op[3:0] == 4'h2) begin
        res.bus_address = pget(ns, i); res.bus_is_write = 1'b1; res.bus_write_data = ns.a;
      end else if (ns.op < 8'h40 && ns.op[3:0] == 4'ha) begin
        res.bus_address = pget(ns, i);
      end else if (ns.op[7:3] == 5'b01110 && ns.op != OP_HALT) begin
        res.bus_address = hl; res.bus_is_write = 1'b1;
        res.bus_write_data = rget(ns, ns.op[2:0]);
      end else if (ns.op >= 8'h40 && ns.op < 8'hc0 && ns.op[2:0] == 3'd6) begin
        res.bus_address = hl;
      end
    end
    res.instr_retired = fin;
    res.retired_opcode = fin ? ns.op : 8'h00;
    res.retired_cycles = cyc;
    res.unimplemented_op = unimpl;
    res.stop_or_halt = hlt;
    res.accumulator = ns.a;
    res.flags_znhc = ns.f;
  end

endmodule

>>> rtl/sm83_instruction_core.sv
// Top level of the SM83 instruction core: state registers and result register.
//
//   channel | direction | payload
//   in_     | sink      | kind, read_data (one completed bus cycle)
//   out_    | source    | next bus request, retirement report, A and flags
//   cfg_    | write     | start_address
//
// Each input transaction is processed by the combinational step logic, which
// runs between the state registers and the result register.
// A new transaction is taken every cycle while the result register is empty
// or being drained in the same cycle; only a stalled output holds the input.
// Synchronous active-low reset clears the state, including the program counter,
// and resets start_address to zero.
module sm83_instruction_core import sm83_pkg::*; (
  input  logic            clk,
  input  logic            rst_n,
  sm83_in_if.sink         in_ch,
  sm83_out_if.source      out_ch,
  input  logic            cfg_we,
  input  logic [15:0]     cfg_wdata
);

  sm83_state_t st_r, st_nxt;
  sm83_out_t   res_r, res_nxt;
  logic        out_valid_r;
  logic [15:0] start_r;
  logic        take;

  // Input is taken whenever the result register can accept a new result.
  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign take = in_ch.valid && in_ch.ready;

  sm83_exec u_exec (
    .st        (st_r),
    .start_addr(start_r),
    .in        (in_ch.data),
    .ns        (st_nxt),
    .res       (res_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_r     <= 16'h0000;
      st_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      // The new start address takes effect at the next start transaction.
      if (cfg_we) begin
        start_r <= cfg_wdata;
      end
      if (take) begin
        st_r <= st_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) res_r <= res_nxt;
  end

  assign out_ch.valid = out_valid_r;
  assign out_ch.data  = res_r;

endmodule

>>> rtl/sm83_checker.sv
// Port-level checker for the SM83 instruction core, bound to the top level.
module sm83_checker import sm83_pkg::*; (
  input logic      clk,
  input logic      rst_n,
  input logic      in_valid,
  input logic      in_ready,
  input logic      out_valid,
  input logic      out_ready,
  input sm83_out_t out_data
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input stalled with empty output");

  a_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> out_valid)
    else $error("accepted transaction produced no result");

  a_retire: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.instr_retired |->
      out_data.retired_cycles == 5'd0 && !out_data.stop_or_halt && !out_data.unimplemented_op)
    else $error("retirement fields set without retirement");

endmodule

bind sm83_instruction_core sm83_checker u_sm83_checker (
  .clk      (clk),
  .rst_n    (rst_n),
  .in_valid (in_ch.valid),
  .in_ready (in_ch.ready),
  .out_valid(out_ch.valid),
  .out_ready(out_ch.ready),
  .out_data (out_ch.data)
);

>>> tb/sv/sm83_core_checker.sv
// Checker for the SM83 core: predicts each result from the input stream and compares.
module sm83_core_checker import sm83_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  sm83_in_if          in_ch,
  sm83_out_if         out_ch,
  input  logic        cfg_we,
  input  logic [15:0] cfg_wdata,
  output int          fail_count,
  output int          pending,
  output int          retired_count
);
  timeunit 1ns;
  timeprecision 1ps;

  // Predicted architectural state.
  logic [15:0] boot_pc;
  logic [7:0]  acc;
  logic [7:0]  regs [6];
  logic [15:0] sp, pc;
  logic [3:0]  flg;
  logic [7:0]  cur_op;
  logic [2:0]  phase;
  logic [7:0]  tmp [2];
  bit          ret, ret_unimpl, ret_halt;
  logic [4:0]  ret_cyc;

  sm83_out_t expected_bus_q [$];

  assign pending = expected_bus_q.size();

  function automatic logic [7:0] rd_reg(int sel);
    sel = sel & 7;
    if (sel == 7) return acc;
    if (sel == 6) return 8'h00;
    return regs[sel];
  endfunction

  task automatic wr_reg(int sel, logic [7:0] v);
    sel = sel & 7;
    if (sel == 7) acc = v;
    else if (sel < 6) regs[sel] = v;
  endtask

  function automatic logic [15:0] pair(int i);
    i = i & 3;
    if (i == 3) return sp;
    return {regs[2*i], regs[2*i+1]};
  endfunction

  task automatic set_pair(int i, logic [15:0] v);
    i = i & 3;
    if (i == 3) sp = v;
    else begin
      regs[2*i]   = v[15:8];
      regs[2*i+1] = v[7:0];
    end
  endtask

  task automatic retire(int cyc);
    ret     = 1;
    ret_cyc = cyc;
    phase   = 0;
  endtask

  function automatic bit cond_ok(logic [7:0] code);
    case (code[4:3])
      2'd0:    return (flg & FLAG_Z) == 0;
      2'd1:    return (flg & FLAG_Z) != 0;
      2'd2:    return (flg & FLAG_C) == 0;
      default: return (flg & FLAG_C) != 0;
    endcase
  endfunction

  // Eight-bit increment or decrement; the carry flag is kept.
  task automatic inc_dec(logic [7:0] v, bit down, output logic [7:0] r);
    logic [3:0] f;
    r = down ? v - 8'd1 : v + 8'd1;
    f = flg & FLAG_C;
    if (r == 0) f |= FLAG_Z;
    if (down) begin
      f |= FLAG_N;
      if (r[3:0] == 4'hf) f |= FLAG_H;
    end else if (r[3:0] == 4'h0) f |= FLAG_H;
    flg = f;
  endtask

  task automatic alu_op(int sel, int v);
    int a, cin, r;
    logic [3:0] f;
    a = acc;
    cin = 0;
    f = 0;
    sel = sel & 7;
    if (sel == 0 || sel == 1) begin
      if (sel == 1) cin = flg[0];
      r = a + v + cin;
      if ((a & 15) + (v & 15) + cin > 15) f |= FLAG_H;
      if (r > 255) f |= FLAG_C;
      r = r & 255;
      acc = r;
    end else if (sel == 2 || sel == 3 || sel == 7) begin
      if (sel == 3) cin = flg[0];
      f = FLAG_N;
      if ((a & 15) < (v & 15) + cin) f |= FLAG_H;
      if (a < v + cin) f |= FLAG_C;
      r = (a + 512 - v - cin) & 255;
      if (sel != 7) acc = r;
    end else begin
      if (sel == 4) begin
        r = a & v;
        f = FLAG_H;
      end else if (sel == 5) r = a ^ v;
      else r = a | v;
      acc = r;
    end
    if (r == 0) f |= FLAG_Z;
    flg = f;
  endtask

  task automatic add_hl(int s);
    int h, r;
    logic [3:0] f;
    h = pair(2);
    r = h + s;
    f = flg & FLAG_Z;
    if ((h & 'hfff) + (s & 'hfff) > 'hfff) f |= FLAG_H;
    if (r > 'hffff) f |= FLAG_C;
    flg = f;
    set_pair(2, r[15:0]);
  endtask

  // Rotates on A, DAA, CPL, SCF and CCF.
  task automatic acc_misc(logic [7:0] code);
    int a, c, f;
    a = acc;
    c = flg[0];
    f = flg;
    case (code)
      8'h07: begin c = a >> 7; a = (a << 1) | c; f = c; end
      8'h17: begin f = a >> 7; a = (a << 1) | c; end
      8'h0f: begin c = a & 1; a = (a >> 1) | (c << 7); f = c; end
      8'h1f: begin f = a & 1; a = (a >> 1) | (c << 7); end
      8'h27: begin
        if ((f & FLAG_N) == 0) begin
          if (c != 0 || a > 'h99) begin
            a += 'h60;
            c = 1;
          end
          if ((f & FLAG_H) != 0 || (a & 15) > 9) a += 6;
        end else begin
          if (c != 0) a += 'h100 - 'h60;
          if ((f & FLAG_H) != 0) a += 'h100 - 6;
        end
        a = a & 255;
        f = (f & FLAG_N) | c | ((a == 0) ? FLAG_Z : 0);
      end
      8'h2f: begin a = ~a; f |= FLAG_N | FLAG_H; end
      8'h37: f = (f & FLAG_Z) | FLAG_C;
      default: f = (f & FLAG_Z) | (c ^ 1);
    endcase
    acc = a[7:0];
    flg = f[3:0];
  endtask

  function automatic bit needs_bus(logic [7:0] code);
    if (code < 8'h40) begin
      if (code == OP_LDSP || code[2:0] == 3'd6) return 1;
      if (code == OP_INCM || code == OP_DECM) return 1;
      if (code[3:0] == 4'h1 || code[3:0] == 4'h2 || code[3:0] == 4'ha) return 1;
      return code == OP_JR || code == 8'h20 || code == 8'h28 || code == 8'h30 ||
             code == 8'h38;
    end
    if (code < 8'h80) return code != OP_HALT && (code[2:0] == 3'd6 || code[7:3] == 5'b01110);
    if (code < 8'hc0) return code[2:0] == 3'd6;
    return code == 8'hc2 || code == OP_JP || code == 8'hca || code == 8'hd2 || code == 8'hda;
  endfunction

  // One-byte instructions finish on the opcode fetch itself.
  task automatic exec_single(logic [7:0] code);
    int r, i;
    logic [7:0] v;
    r = code[5:3];
    i = code[5:4];
    if (code == OP_STOP || code == OP_HALT) begin
      ret_halt = 1;
      retire(0);
    end else if (code >= 8'h40 && code < 8'h80) begin
      wr_reg(r, rd_reg(code[2:0]));
      retire(4);
    end else if (code >= 8'h80 && code < 8'hc0) begin
      alu_op(r, rd_reg(code[2:0]));
      retire(4);
    end else if (code == OP_JPHL) begin
      pc = pair(2);
      retire(4);
    end else if (code >= 8'hc0) begin
      ret_unimpl = 1;
      retire(4);
    end else begin
      case (code[2:0])
        3'd3: begin
          set_pair(i, pair(i) + (code[3] ? 16'hffff : 16'h0001));
          retire(8);
        end
        3'd1: begin add_hl(pair(i)); retire(8); end
        3'd4: begin inc_dec(rd_reg(r), 0, v); wr_reg(r, v); retire(4); end
        3'd5: begin inc_dec(rd_reg(r), 1, v); wr_reg(r, v); retire(4); end
        3'd7: begin acc_misc(code); retire(4); end
        default: retire(4);
      endcase
    end
  endtask

  // Later bus cycles of multi-cycle instructions.
  task automatic exec_phase(logic [7:0] rd);
    logic [7:0] code, v;
    int p, r;
    code = cur_op;
    p = phase;
    r = code[5:3];
    if (code == OP_LDSP) begin
      if (p <= 2) begin
        tmp[p-1] = rd;
        pc++;
      end
      if (p < 4) phase = p + 1;
      else retire(20);
    end else if (code < 8'h40 && code[3:0] == 4'h1) begin
      pc++;
      if (p == 1) begin
        tmp[0] = rd;
        phase = 2;
      end else begin
        set_pair(code[5:4], {rd, tmp[0]});
        retire(12);
      end
    end else if (code == OP_LDHLN) begin
      if (p == 1) begin
        pc++;
        tmp[0] = rd;
        phase = 2;
      end else retire(12);
    end else if (code == OP_INCM || code == OP_DECM) begin
      if (p == 1) begin
        inc_dec(rd, code == OP_DECM, v);
        tmp[0] = v;
        phase = 2;
      end else retire(12);
    end else if (code < 8'h40 && code[2:0] == 3'd6) begin
      pc++;
      wr_reg(r, rd);
      retire(8);
    end else if (code < 8'h40 && (code[3:0] == 4'h2 || code[3:0] == 4'ha)) begin
      if (code[3:0] == 4'ha) acc = rd;
      if (code[7:4] == 4'h2) set_pair(2, pair(2) + 16'h0001);
      if (code[7:4] == 4'h3) set_pair(2, pair(2) + 16'hffff);
      retire(8);
    end else if (code < 8'h40) begin
      pc++;
      if (code == OP_JR || cond_ok(code)) begin
        pc = pc + {{8{rd[7]}}, rd};
        retire(12);
      end else retire(8);
    end else if (code < 8'h80) begin
      if (code[7:3] != 5'b01110) wr_reg(r, rd);
      retire(8);
    end else if (code < 8'hc0) begin
      alu_op(r, rd);
      retire(8);
    end else begin
      pc++;
      if (p == 1) begin
        tmp[0] = rd;
        phase = 2;
      end else if (code == OP_JP || cond_ok(code)) begin
        pc = {rd, tmp[0]};
        retire(16);
      end else retire(12);
    end
  endtask

  task automatic next_access(output sm83_out_t o);
    logic [7:0] code;
    logic [15:0] base;
    int p, i;
    code = cur_op;
    p = phase;
    i = code[5:4];
    o.bus_address = pc;
    o.bus_write_data = 0;
    o.bus_is_write = 0;
    if (p == 0) return;
    if (i == 3) i = 2;
    base = {tmp[1], tmp[0]};
    if (code == OP_LDSP && p >= 3) begin
      o.bus_is_write = 1;
      o.bus_address = (p == 3) ? base : base + 16'd1;
      o.bus_write_data = (p == 3) ? sp[7:0] : sp[15:8];
    end else if (code == OP_LDHLN && p == 2) begin
      o.bus_address = pair(2);
      o.bus_is_write = 1;
      o.bus_write_data = tmp[0];
    end else if (code == OP_INCM || code == OP_DECM) begin
      o.bus_address = pair(2);
      if (p == 2) begin
        o.bus_is_write = 1;
        o.bus_write_data = tmp[0];
      end
    end else if (code < 8'h40 && code[3:0] == 4'h2) begin
      o.bus_address = pair(i);
      o.bus_is_write = 1;
      o.bus_write_data = acc;
    end else if (code < 8'h40 && code[3:0] == 4'ha) begin
      o.bus_address = pair(i);
    end else if (code[7:3] == 5'b01110 && code != OP_HALT) begin
      o.bus_address = pair(2);
      o.bus_is_write = 1;
      o.bus_write_data = rd_reg(code[2:0]);
    end else if (code >= 8'h40 && code < 8'hc0 && code[2:0] == 3'd6) begin
      o.bus_address = pair(2);
    end
  endtask

  task automatic predict_bus_cycle(sm83_in_t t, output sm83_out_t o);
    ret = 0;
    ret_cyc = 0;
    ret_unimpl = 0;
    ret_halt = 0;
    if (!t.kind) begin
      pc = boot_pc;
      phase = 0;
    end else if (phase == 0) begin
      cur_op = t.read_data;
      pc++;
      if (needs_bus(t.read_data)) phase = 1;
      else exec_single(t.read_data);
    end else exec_phase(t.read_data);
    next_access(o);
    o.instr_retired = ret;
    o.retired_opcode = ret ? cur_op : 8'h00;
    o.retired_cycles = ret ? ret_cyc : 5'd0;
    o.unimplemented_op = ret_unimpl;
    o.stop_or_halt = ret_halt;
    o.accumulator = acc;
    o.flags_znhc = flg;
  endtask

  task automatic check_field(string nm, int e, int g);
    if (e != g) begin
      $display("%0t ns: mismatch on %s: expected 0x%0h, actual 0x%0h", $time, nm, e, g);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    sm83_out_t e, g;
    if (!rst_n) begin
      boot_pc = 0;
      acc = 0;
      foreach (regs[k]) regs[k] = 0;
      sp = 0;
      pc = 0;
      flg = 0;
      cur_op = 0;
      phase = 0;
      tmp[0] = 0;
      tmp[1] = 0;
      expected_bus_q.delete();
      fail_count = 0;
      retired_count = 0;
    end else begin
      // The result leaving now was caused by an earlier transaction, so check it first.
      if (out_ch.valid && out_ch.ready) begin
        g = out_ch.data;
        if (expected_bus_q.size() == 0) begin
          $display("%0t ns: unexpected result transaction, actual 0x%0h", $time, g);
          fail_count++;
        end else begin
          e = expected_bus_q.pop_front();
          check_field("bus_address", e.bus_address, g.bus_address);
          check_field("bus_write_data", e.bus_write_data, g.bus_write_data);
          check_field("bus_is_write", e.bus_is_write, g.bus_is_write);
          check_field("instr_retired", e.instr_retired, g.instr_retired);
          check_field("retired_opcode", e.retired_opcode, g.retired_opcode);
          check_field("retired_cycles", e.retired_cycles, g.retired_cycles);
          check_field("unimplemented_op", e.unimplemented_op, g.unimplemented_op);
          check_field("stop_or_halt", e.stop_or_halt, g.stop_or_halt);
          check_field("accumulator", e.accumulator, g.accumulator);
          check_field("flags_znhc", e.flags_znhc, g.flags_znhc);
          if (e.instr_retired) retired_count++;
        end
      end
      if (in_ch.valid && in_ch.ready) begin
        predict_bus_cycle(in_ch.data, e);
        expected_bus_q.push_back(e);
      end
      if (cfg_we) boot_pc = cfg_wdata;
    end
  end
endmodule

>>> tb/sv/testbench.sv
// Top of the SM83 core testbench: clock, reset, stimulus, configuration and verdict.
module testbench import sm83_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  logic        clk;
  logic        rst_n;
  logic        cfg_we;
  logic [15:0] cfg_wdata;
  int          fail_count, pending, retired_count;
  int          sent, cycles;
  bit          in_quiet, out_quiet;

  sm83_in_if  in_ch ();
  sm83_out_if out_ch ();

  sm83_instruction_core DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  sm83_core_checker checker_i (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_ch         (in_ch),
    .out_ch        (out_ch),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .fail_count    (fail_count),
    .pending       (pending),
    .retired_count (retired_count)
  );

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // Watchdog: a run that stalls far beyond the slowest legal pace is a failure.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 400000) begin
      $display("Timeout after %0d cycles", cycles);
      $display("sm83_instruction_core verification failed");
      $finish;
    end
  end

  // Sends one bus-cycle transaction. It is called at a falling edge and returns at
  // a falling edge. With no gap drawn, valid stays high so transactions go back to back.
  task automatic send_bus_cycle(bit k, logic [7:0] rd);
    int gap;
    gap = in_quiet ? 0 : $urandom_range(0, 19);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.data.kind <= k;
    in_ch.data.read_data <= rd;
    in_ch.valid <= 1'b1;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    @(negedge clk);
    sent++;
    if ($urandom_range(0, 99) == 0) in_quiet = !in_quiet;
  endtask

  // Writes start_address once every expected result is back and the core is idle.
  task automatic set_start_address(logic [15:0] v);
    in_ch.valid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    repeat (4) @(negedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(negedge clk);
    cfg_we <= 1'b0;
    // A start transaction makes the new address take effect.
    send_bus_cycle(1'b0, 8'h00);
  endtask

  // Random bytes: any byte stream is a legal program, so most content is random, with
  // jumps favored so that control flow is exercised often and a few stray restarts.
  task automatic random_run(int n);
    logic [7:0] jumps [6];
    jumps = '{8'hc2, OP_JP, 8'hca, 8'hd2, 8'hda, OP_JPHL};
    repeat (n) begin
      if ($urandom_range(0, 49) == 0) send_bus_cycle(1'b0, 8'($urandom));
      else if ($urandom_range(0, 9) == 0) send_bus_cycle(1'b1, jumps[$urandom_range(0, 5)]);
      else send_bus_cycle(1'b1, 8'($urandom));
    end
  endtask

  // Result side: ready is withheld for a random number of cycles per transaction.
  initial begin
    int stall;
    out_ch.ready = 1'b0;
    @(negedge clk);
    forever begin
      stall = out_quiet ? 0 : $urandom_range(0, 19);
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ch.ready <= 1'b1;
      @(posedge clk);
      while (!out_ch.valid) @(posedge clk);
      @(negedge clk);
      if ($urandom_range(0, 99) == 0) out_quiet = !out_quiet;
    end
  end

  initial begin
    logic [7:0] program_bytes [$];
    int wait_cycles;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_wdata = 16'h0000;
    in_ch.valid = 1'b0;
    in_ch.data = '0;
    cycles = 0;
    sent = 0;
    in_quiet = 0;
    out_quiet = 0;
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed part. The first transaction is a completion with no start before it.
    // The bytes walk through LD A,n to 0xFF, INC A wrapping to zero, storing SP to
    // an immediate address, INC (HL) with a half carry, DEC (HL), DAA, an absolute
    // jump to the top of memory, a backward JR, a conditional JR, JP (HL), an
    // unimplemented opcode, STOP and HALT.
    program_bytes = '{8'h3e, 8'hff, 8'h3c, OP_LDSP, 8'h34, 8'h12, 8'h00, 8'h00,
                      OP_INCM, 8'h0f, 8'h00, OP_DECM, 8'h00, 8'h00, 8'h27,
                      OP_JP, 8'hff, 8'hff, OP_JR, 8'h80, 8'h28, 8'h7f, OP_JPHL,
                      8'hff, OP_STOP, OP_HALT};
    foreach (program_bytes[k]) send_bus_cycle(1'b1, program_bytes[k]);

    // Random part, under several start addresses including both extremes.
    set_start_address(16'hffff);
    random_run(450);
    set_start_address(16'($urandom));
    random_run(450);
    set_start_address(16'h0000);
    random_run(450);
    set_start_address(16'h8000);
    random_run(400);

    in_ch.valid <= 1'b0;
    wait_cycles = 0;
    while (pending != 0 && wait_cycles < 2000) begin
      @(negedge clk);
      wait_cycles++;
    end
    repeat (10) @(negedge clk);
    if (pending != 0) begin
      $display("%0d expected results never arrived", pending);
      fail_count++;
    end

    $display("Sent %0d bus-cycle transactions under five start addresses;", sent);
    $display("%0d instructions retired and were checked with every result field.",
             retired_count);
    if (fail_count == 0) begin
      $display("sm83_instruction_core verification clean");
    end else begin
      $display("sm83_instruction_core verification failed");
    end
    $finish;
  end
endmodule
